// File: hdl/ps2enc_pkg.sv
// ----------------------------------------------------------------------------
// ps2enc_pkg
// Types, byte constants and the sequence builder for the PS/2 set 2
// make/break encoder.
// ----------------------------------------------------------------------------
package ps2enc_pkg;

  localparam int unsigned MaxBytes = 6;
  localparam int unsigned IdxW     = $clog2(MaxBytes);
  localparam int unsigned LenW     = $clog2(MaxBytes + 1);

  localparam logic [7:0] PfxBreak = 8'hF0;
  localparam logic [7:0] PfxExt   = 8'hE0;
  localparam logic [7:0] LShift   = 8'h12;
  localparam logic [7:0] RShift   = 8'h59;

  typedef enum logic [2:0] {
    KC_UNKNOWN    = 3'd0,
    KC_NORMAL     = 3'd1,
    KC_EXTENDED   = 3'd2,
    KC_NAV        = 3'd3,
    KC_SHIFT_UNDO = 3'd4
  } key_class_e;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [LenW-1:0]          len;
  } seq_t;

  // Builds the full byte sequence of one key event. Unknown and undefined
  // classes give an empty sequence.
  function automatic seq_t build_seq(logic [7:0] code, logic [2:0] cls,
                                     logic down, logic shift);
    seq_t s;
    s.bytes = '0;
    s.len   = '0;
    unique case (cls)
      KC_NORMAL: begin
        if (down) begin
          s.bytes[0] = code;
          s.len      = LenW'(1);
        end else begin
          s.bytes[0] = PfxBreak;
          s.bytes[1] = code;
          s.len      = LenW'(2);
        end
      end
      KC_EXTENDED: begin
        if (down) begin
          s.bytes[0] = PfxExt;
          s.bytes[1] = code;
          s.len      = LenW'(2);
        end else begin
          s.bytes[0] = PfxExt;
          s.bytes[1] = PfxBreak;
          s.bytes[2] = code;
          s.len      = LenW'(3);
        end
      end
      KC_NAV: begin
        if (down) begin
          s.bytes[0] = PfxExt;
          s.bytes[1] = LShift;
          s.bytes[2] = PfxExt;
          s.bytes[3] = code;
          s.len      = LenW'(4);
        end else begin
          s.bytes[0] = PfxExt;
          s.bytes[1] = PfxBreak;
          s.bytes[2] = code;
          s.bytes[3] = PfxExt;
          s.bytes[4] = PfxBreak;
          s.bytes[5] = LShift;
          s.len      = LenW'(6);
        end
      end
      KC_SHIFT_UNDO: begin
        if (down) begin
          if (shift) begin
            s.bytes[0] = PfxExt;
            s.bytes[1] = PfxBreak;
            s.bytes[2] = LShift;
            s.bytes[3] = PfxExt;
            s.bytes[4] = code;
            s.len      = LenW'(5);
          end else begin
            s.bytes[0] = PfxExt;
            s.bytes[1] = code;
            s.len      = LenW'(2);
          end
        end else begin
          s.bytes[0] = PfxExt;
          s.bytes[1] = PfxBreak;
          s.bytes[2] = code;
          if (shift) begin
            s.bytes[3] = PfxExt;
            s.bytes[4] = RShift;
            s.len      = LenW'(5);
          end else begin
            s.len      = LenW'(3);
          end
        end
      end
      default: begin
        s.len = '0;
      end
    endcase
    return s;
  endfunction

endpackage

// File: hdl/key_event_to_ps2_set2_bytes.sv
// ----------------------------------------------------------------------------
// key_event_to_ps2_set2_bytes
// Turns one key event into its PS/2 scan code set 2 byte sequence, one byte
// per output transaction, with a last flag on the final byte.
// ----------------------------------------------------------------------------
// The first byte of an accepted event passes the event register and then the
// output register before it reaches the output.
// Throughput: one output byte per cycle while the output is ready; an event
// of N bytes (1 to 6) holds the event register until its final byte is loaded;
// an unknown key leaves with no byte, and the single output port sets the rate.
// Reset clears the event valid flag, the byte index and the output valid.
module key_event_to_ps2_set2_bytes (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] scan_code_i,
  input  logic [2:0] key_class_i,
  input  logic       pressed_i,
  input  logic       shift_held_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] code_byte_o,
  output logic       last_o
);
  import ps2enc_pkg::*;

  // Event register: holds the accepted key event while its bytes go out.
  logic            ev_valid_q, ev_valid_d;
  logic [7:0]      ev_code_q;
  logic [2:0]      ev_class_q;
  logic            ev_down_q;
  logic            ev_shift_q;

  // Index of the next byte of the held event's sequence.
  logic [IdxW-1:0] idx_q, idx_d;

  // Output register, which parts the event side from the output handshake.
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q;
  logic            out_last_q;

  seq_t            seq;
  logic            out_free;
  logic            emit;
  logic            final_byte;
  logic            advance;
  logic            in_take;
  logic [7:0]      emit_byte;

  // The whole sequence is built combinationally from the event register;
  // the byte index picks one entry per cycle while the output register has room.
  assign seq       = build_seq(ev_code_q, ev_class_q, ev_down_q, ev_shift_q);
  assign emit_byte = seq.bytes[idx_q];

  // The output register can take a new byte when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  // A byte goes out whenever an event with a nonempty sequence is held and
  // the output register has room. An unknown key is dropped from the event
  // register without producing any transaction.
  assign final_byte = (idx_q == IdxW'(seq.len - LenW'(1)));
  assign emit       = ev_valid_q && (seq.len != '0) && out_free;
  assign advance    = ev_valid_q && ((seq.len == '0) || (emit && final_byte));

  // The next event is taken while the final byte of the current one is
  // loaded, so short sequences stream back to back.
  assign in_ready_o = !ev_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    ev_valid_d = ev_valid_q;
    if (in_take) begin
      ev_valid_d = 1'b1;
    end else if (advance) begin
      ev_valid_d = 1'b0;
    end

    idx_d = idx_q;
    if (advance) begin
      idx_d = '0;
    end else if (emit) begin
      idx_d = idx_q + IdxW'(1);
    end

    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q  <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ev_valid_q  <= ev_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ev_code_q  <= scan_code_i;
      ev_class_q <= key_class_i;
      ev_down_q  <= pressed_i;
      ev_shift_q <= shift_held_i;
    end
    if (emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= final_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign code_byte_o = out_byte_q;
  assign last_o      = out_last_q;

`ifndef SYNTHESIS
  // The byte index always stays inside the held event's sequence.
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_valid_q && (seq.len != '0)) |-> (LenW'(idx_q) < seq.len))
    else $error("byte index beyond sequence length");

  // With no event held the index rests at the first byte.
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ev_valid_q |-> (idx_q == '0))
    else $error("byte index not at zero while no event is held");

  // Loading the final byte of a sequence restarts the index for the next one.
  a_idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && final_byte) |=> (idx_q == '0))
    else $error("byte index not restarted after final byte");

  // A loaded final byte shows up on the output with its last flag.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && final_byte) |=> (out_valid_o && last_o))
    else $error("final byte without last flag");
`endif

endmodule

// File: sim/key_event_to_ps2_set2_bytes_tb.sv
// ----------------------------------------------------------------------------
// key_event_to_ps2_set2_bytes_tb
// Self-checking testbench for the PS/2 set 2 make/break encoder. Key events
// go in through a valid/ready port. A predictor in this file builds the byte
// sequence for every accepted event, and each output byte is compared, with
// its last flag, against the oldest byte still owed. Directed events cover
// every key class, both directions and the shift cases. Random events follow,
// with idle gaps on both sides, a long output stall and a full drain pause.
// ----------------------------------------------------------------------------
module key_event_to_ps2_set2_bytes_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2enc_pkg::*;

  // The run is stopped here if the block hangs. The slowest correct run is far
  // shorter: about 100 events, each at most 6 bytes, each byte waiting out at
  // most one output stall, plus an idle gap per event.
  localparam int unsigned CycleLimit  = 200000;
  // The output register directly follows the event register, so DrainCycles of
  // waiting after the last byte are enough to catch anything extra.
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItems = 60;
  // Class codes above the shift-undo code are undefined and must stay silent.
  localparam logic [2:0]  KcFirstUndefined = 3'(KC_SHIFT_UNDO) + 3'd1;

  // One byte of a set 2 sequence as it should appear on the output.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } ps2_byte_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] scan_code_i;
  logic [2:0] key_class_i;
  logic       pressed_i;
  logic       shift_held_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] code_byte_o;
  logic       last_o;

  // Bytes owed by the block, oldest first.
  ps2_byte_t   owed_bytes[$];

  int unsigned error_count;
  int unsigned bytes_checked;
  int unsigned cycle_count;
  int unsigned class_hits[8];

  // When idle_on is low, neither side inserts random gaps or stalls.
  bit          idle_on;
  // A nonzero value asks the output side to hold ready low for that many
  // cycles. The output process takes the request and clears it.
  int unsigned hold_request;

  key_event_to_ps2_set2_bytes u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .scan_code_i (scan_code_i),
    .key_class_i (key_class_i),
    .pressed_i   (pressed_i),
    .shift_held_i(shift_held_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .code_byte_o (code_byte_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Gap length in cycles: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Mostly the four real classes; a few unknown or undefined codes mixed in.
  function automatic logic [2:0] pick_class();
    if ($urandom_range(0, 99) < 8) begin
      if ($urandom_range(0, 3) == 0) return KC_UNKNOWN;
      return 3'($urandom_range(int'(KcFirstUndefined), 7));
    end
    return 3'($urandom_range(int'(KC_NORMAL), int'(KC_SHIFT_UNDO)));
  endfunction

  // Builds the set 2 byte sequence of one key event and appends it to the
  // bytes owed, with the last flag on its final byte. Unknown and undefined
  // classes add nothing.
  task automatic encode_key_event(logic [7:0] code, logic [2:0] cls, logic down,
                                  logic shift);
    logic [7:0] seq[$];
    ps2_byte_t  b;
    case (cls)
      KC_NORMAL: begin
        if (!down) seq.push_back(PfxBreak);
        seq.push_back(code);
      end
      KC_EXTENDED: begin
        seq.push_back(PfxExt);
        if (!down) seq.push_back(PfxBreak);
        seq.push_back(code);
      end
      KC_NAV: begin
        // A fake left shift wraps the key, as if num lock were on.
        if (down) begin
          seq.push_back(PfxExt);
          seq.push_back(LShift);
          seq.push_back(PfxExt);
          seq.push_back(code);
        end else begin
          seq.push_back(PfxExt);
          seq.push_back(PfxBreak);
          seq.push_back(code);
          seq.push_back(PfxExt);
          seq.push_back(PfxBreak);
          seq.push_back(LShift);
        end
      end
      KC_SHIFT_UNDO: begin
        // A held shift is released (left) before the make and pressed again
        // (right) after the break.
        if (down) begin
          if (shift) begin
            seq.push_back(PfxExt);
            seq.push_back(PfxBreak);
            seq.push_back(LShift);
          end
          seq.push_back(PfxExt);
          seq.push_back(code);
        end else begin
          seq.push_back(PfxExt);
          seq.push_back(PfxBreak);
          seq.push_back(code);
          if (shift) begin
            seq.push_back(PfxExt);
            seq.push_back(RShift);
          end
        end
      end
      default: begin
      end
    endcase
    foreach (seq[i]) begin
      b.value = seq[i];
      b.last  = (i == seq.size() - 1);
      owed_bytes.push_back(b);
    end
  endtask

  task automatic report_mismatch(string what);
    error_count++;
    $display("[%0t] ERROR: %s", $realtime, what);
  endtask

  // Offers one key event after an optional idle gap and holds it until the
  // block takes it. The prediction is made at the accepting edge.
  task automatic send_key_event(logic [7:0] code, logic [2:0] cls, logic down,
                                logic shift);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    scan_code_i  = code;
    key_class_i  = cls;
    pressed_i    = down;
    shift_held_i = shift;
    in_valid_i   = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    encode_key_event(code, cls, down, shift);
    class_hits[cls]++;
  endtask

  task automatic send_random_event(output bit real_key);
    logic [2:0] cls;
    cls = pick_class();
    real_key = (cls >= 3'(KC_NORMAL)) && (cls <= 3'(KC_SHIFT_UNDO));
    send_key_event(8'($urandom_range(0, 255)), cls, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
  endtask

  task automatic wait_until_drained();
    while (owed_bytes.size() != 0) @(posedge clk_i);
  endtask

  // Unknown keys and the undefined class codes must produce no bytes at all.
  task automatic test_unknown_keys();
    send_key_event(8'h00, KC_UNKNOWN, 1'b1, 1'b0);
    for (int c = int'(KcFirstUndefined); c <= 7; c++) begin
      send_key_event(8'hFF, 3'(c), 1'(c & 1), 1'(c >> 1));
    end
  endtask

  task automatic test_normal_keys();
    send_key_event(8'h00, KC_NORMAL, 1'b1, 1'b0);
    send_key_event(8'hFF, KC_NORMAL, 1'b0, 1'b1);
    send_key_event(8'h1C, KC_NORMAL, 1'b0, 1'b0);
  endtask

  task automatic test_extended_keys();
    send_key_event(8'hFF, KC_EXTENDED, 1'b1, 1'b1);
    send_key_event(8'h00, KC_EXTENDED, 1'b0, 1'b0);
  endtask

  // The release is the longest sequence the block can send.
  task automatic test_navigation_keys();
    send_key_event(8'h6B, KC_NAV, 1'b1, 1'b0);
    send_key_event(8'h6B, KC_NAV, 1'b0, 1'b1);
  endtask

  // All four press/release and shift combinations, which also shows the
  // left shift going up before the key and the right shift coming back after.
  task automatic test_shift_undo();
    send_key_event(8'h4A, KC_SHIFT_UNDO, 1'b1, 1'b0);
    send_key_event(8'h4A, KC_SHIFT_UNDO, 1'b1, 1'b1);
    send_key_event(8'h4A, KC_SHIFT_UNDO, 1'b0, 1'b1);
    send_key_event(8'h4A, KC_SHIFT_UNDO, 1'b0, 1'b0);
  endtask

  // The output side holds off for a long stretch while navigation releases
  // arrive back to back, so the block fills up and must stall its input.
  task automatic test_output_backpressure();
    bit saved_idle;
    saved_idle   = idle_on;
    idle_on      = 1'b0;
    hold_request = 80;
    repeat (10) send_key_event(8'($urandom_range(0, 255)), KC_NAV, 1'b0,
                               1'($urandom_range(0, 1)));
    idle_on = saved_idle;
  endtask

  // The input side stops until every owed byte is out, then starts again.
  task automatic test_drain_pause();
    bit real_key;
    repeat (5) send_random_event(real_key);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait_until_drained();
    repeat (5) send_random_event(real_key);
  endtask

  // Random events in blocks of fifteen. Most blocks idle on both sides; every
  // fourth runs at full rate. Unknown keys are not counted toward the total.
  task automatic test_random_events();
    bit          real_key;
    int unsigned counted;
    counted = 0;
    while (counted < RandomItems) begin
      idle_on = ((counted / 15) % 4) != 3;
      send_random_event(real_key);
      if (real_key) counted++;
    end
    idle_on = 1'b1;
  endtask

  // Output ready: honors a requested long hold first, then random stalls.
  initial begin : sink_ready
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left  = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if (idle_on && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  // Every output transaction must match the oldest owed byte, field by field.
  always @(posedge clk_i) begin : byte_checker
    ps2_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      bytes_checked++;
      if (owed_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", code_byte_o, last_o));
      end else begin
        want = owed_bytes.pop_front();
        if (code_byte_o !== want.value) begin
          report_mismatch($sformatf("code_byte %02h, expected %02h", code_byte_o,
                                    want.value));
        end
        if (last_o !== want.last) begin
          report_mismatch($sformatf("last %0b on byte %02h, expected %0b", last_o,
                                    code_byte_o, want.last));
        end
      end
    end
  end

  // Hang guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cycle_count,
               owed_bytes.size());
      $display("key_event_to_ps2_set2_bytes: mismatch");
      $finish;
    end
  end

  initial begin : run_tests
    in_valid_i   = 1'b0;
    scan_code_i  = 8'h00;
    key_class_i  = KC_UNKNOWN;
    pressed_i    = 1'b0;
    shift_held_i = 1'b0;
    idle_on      = 1'b1;
    hold_request = 0;
    error_count  = 0;
    bytes_checked = 0;
    cycle_count  = 0;
    rst_ni       = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_unknown_keys();
    test_normal_keys();
    test_extended_keys();
    test_navigation_keys();
    test_shift_undo();
    test_output_backpressure();
    test_drain_pause();
    test_random_events();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait_until_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d unknown/undefined, %0d normal, %0d extended, %0d navigation,",
             class_hits[0] + class_hits[5] + class_hits[6] + class_hits[7],
             class_hits[KC_NORMAL], class_hits[KC_EXTENDED], class_hits[KC_NAV]);
    $display("%0d shift-undo key events; %0d output bytes checked, %0d errors",
             class_hits[KC_SHIFT_UNDO], bytes_checked, error_count);
    if (error_count == 0) begin
      $display("key_event_to_ps2_set2_bytes: match");
    end else begin
      $display("key_event_to_ps2_set2_bytes: mismatch");
    end
    $finish;
  end

endmodule

// File: key_event_to_ps2_set2_bytes.f
hdl/ps2enc_pkg.sv
hdl/key_event_to_ps2_set2_bytes.sv
sim/key_event_to_ps2_set2_bytes_tb.sv
